### design/time_bucket_aggregator_core_macros.svh
// assertion macros used by the time bucket aggregator back end
`ifndef TIME_BUCKET_AGGREGATOR_CORE_MACROS_SVH
`define TIME_BUCKET_AGGREGATOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tba_pkg.sv
// shared constants for the time bucket aggregator
package tba_pkg;

    // fixed field widths
    localparam int TIME_W    = 64;
    localparam int RES_W     = 64;
    localparam int BLEN_W    = 32;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_MODE   = 2'd3;

    // reduce mode codes
    localparam logic [MODE_W-1:0] MODE_SUM   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AVG   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIN   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MAX   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd4;

    // reset value of the bucket length register
    localparam logic [BLEN_W-1:0] BLEN_RESET = 32'd60;

    // signed 64-bit saturation bounds
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

endpackage

### design/time_bucket_aggregator_core.sv
// Time bucket aggregator top level: one point per cycle at the front end while s_tready is high.
// Path: sum, min, max and count results go from the record queue straight to the output
// register; average results first pass the 64-step restoring divider, one quotient bit a cycle.
// Throughput: 1 point per cycle while the queue has room; a point with two results holds s_tready
// low until the second is queued; an average record is popped only while the divider is idle.
// Reset: aresetn synchronous active low; clears config to defaults, bucket state and queue.
module time_bucket_aggregator_core import tba_pkg::*; #(
    parameter int VALUE_WIDTH = 40,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [CFG_IDX_W-1:0]             cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    // point stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: point_time, point_value, zero fill
    input  logic [((TIME_W+VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                             s_tlast,    // end_of_stream
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: bucket_start, bucket_result
    output logic [TIME_W+RES_W-1:0]          m_tdata,
    output logic                             m_tuser,    // bucket_valid
    output logic                             m_tlast     // final_result
);

    localparam int REC_W   = TIME_W + RES_W + COUNT_WIDTH + 3;
    localparam int Q_DEPTH = 4;

    logic [REC_W-1:0]  push_data, pop_data;
    logic              push, pop, q_full, q_empty;
    logic [TIME_W-1:0] res_start;
    logic [RES_W-1:0]  res_value;

    assign cfg_ready = 1'b1;

    // point classification and bucket tracking
    tba_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .REC_W       (REC_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pt_valid  (s_tvalid),
        .pt_ready  (s_tready),
        .pt_time   (s_tdata[TIME_W-1:0]),
        .pt_value  (s_tdata[TIME_W+VALUE_WIDTH-1:TIME_W]),
        .pt_last   (s_tlast),
        .rec_push  (push),
        .rec_data  (push_data),
        .q_full    (q_full)
    );

    // close records between front and back
    tba_queue #(
        .WIDTH (REC_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // result computation and output register
    tba_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .REC_W       (REC_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_data           (pop_data),
        .q_empty          (q_empty),
        .q_pop            (pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_start        (res_start),
        .out_result       (res_value),
        .out_bucket_valid (m_tuser),
        .out_final        (m_tlast)
    );

    assign m_tdata = {res_value, res_start};

endmodule

### design/tba_front.sv
// front end: config registers, bucket tracking and close record generation
module tba_front import tba_pkg::*; #(
    parameter int VALUE_WIDTH = 40,
    parameter int COUNT_WIDTH = 32,
    parameter int REC_W       = 2 * 64 + 32 + 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // point stream
    input  logic                   pt_valid,
    output logic                   pt_ready,
    input  logic [TIME_W-1:0]      pt_time,
    input  logic [VALUE_WIDTH-1:0] pt_value,
    input  logic                   pt_last,
    // record queue write side
    output logic                   rec_push,
    output logic [REC_W-1:0]       rec_data,
    input  logic                   q_full
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    // configuration registers
    logic [TIME_W-1:0] range_start_reg;
    logic [TIME_W-1:0] range_end_reg;
    logic [BLEN_W-1:0] blen_reg;
    logic [MODE_W-1:0] mode_reg;

    // open bucket state
    logic                   open_reg,  open_next;
    logic [TIME_W-1:0]      start_reg, start_next;
    logic [TIME_W-1:0]      limit_reg, limit_next;
    logic [RES_W-1:0]       sum_reg,   sum_next;
    logic [VALUE_WIDTH-1:0] min_reg,   min_next;
    logic [VALUE_WIDTH-1:0] max_reg,   max_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    // second record of a transaction waiting for the queue
    logic             pend_valid_reg, pend_valid_next;
    logic [REC_W-1:0] pend_reg,       pend_next;

    // combinational terms
    logic                   acc;
    logic [RES_W-1:0]       v64;
    logic                   join_pt;
    logic                   opens;
    logic [BLEN_W-1:0]      len;
    logic [TIME_W:0]        limit_sum;
    logic [TIME_W-1:0]      new_limit;
    logic [RES_W-1:0]       sum_add;
    logic                   sum_ovf;
    logic [RES_W-1:0]       sat_sum;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   mid_open;
    logic [TIME_W-1:0]      mid_start;
    logic [TIME_W-1:0]      mid_limit;
    logic [RES_W-1:0]       mid_sum;
    logic [VALUE_WIDTH-1:0] mid_min;
    logic [VALUE_WIDTH-1:0] mid_max;
    logic [COUNT_WIDTH-1:0] mid_count;
    logic                   mode_ok;
    logic                   a_emit, a_final, b_emit, mk_emit;
    logic [REC_W-1:0]       rec_a, rec_b, rec_mk;
    logic [REC_W-1:0]       rec_first, rec_second;
    logic                   has_first, has_second;

    // packs one close record: {final, valid, avg, count, value, start}
    function automatic logic [REC_W-1:0] make_rec(
        input logic [MODE_W-1:0]      mode,
        input logic [TIME_W-1:0]      st,
        input logic [RES_W-1:0]       sm,
        input logic [VALUE_WIDTH-1:0] mn,
        input logic [VALUE_WIDTH-1:0] mx,
        input logic [COUNT_WIDTH-1:0] cnt,
        input logic                   fin
    );
        logic [RES_W-1:0] val;
        unique case (mode)
            MODE_SUM:   val = sm;
            MODE_AVG:   val = sm;
            MODE_MIN:   val = {{(RES_W-VALUE_WIDTH){mn[VALUE_WIDTH-1]}}, mn};
            MODE_MAX:   val = {{(RES_W-VALUE_WIDTH){mx[VALUE_WIDTH-1]}}, mx};
            MODE_COUNT: val = {{(RES_W-COUNT_WIDTH){1'b0}}, cnt};
            default:    val = '0;
        endcase
        return {fin, 1'b1, (mode == MODE_AVG), cnt, val, st};
    endfunction

    assign acc      = pt_valid && pt_ready;
    assign pt_ready = !pend_valid_reg && !q_full;

    // point classification against the open bucket and the range
    assign v64     = {{(RES_W-VALUE_WIDTH){pt_value[VALUE_WIDTH-1]}}, pt_value};
    assign join_pt = open_reg && (pt_time < limit_reg);
    assign opens   = (pt_time >= range_start_reg) && (pt_time <= range_end_reg);

    // saturating bucket end for a new bucket
    assign len       = (blen_reg == '0) ? BLEN_W'(1) : blen_reg;
    assign limit_sum = {1'b0, pt_time} + {{(TIME_W+1-BLEN_W){1'b0}}, len};
    assign new_limit = limit_sum[TIME_W] ? {TIME_W{1'b1}} : limit_sum[TIME_W-1:0];

    // saturating accumulation
    assign sum_add   = sum_reg + v64;
    assign sum_ovf   = (sum_reg[RES_W-1] == v64[RES_W-1]) &&
                       (sum_add[RES_W-1] != sum_reg[RES_W-1]);
    assign sat_sum   = sum_ovf ? (sum_reg[RES_W-1] ? RES_MIN : RES_MAX) : sum_add;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_ONE;

    // bucket state after this point, before end-of-stream clearing
    always_comb begin
        mid_open  = 1'b0;
        mid_start = start_reg;
        mid_limit = limit_reg;
        mid_sum   = sum_reg;
        mid_min   = min_reg;
        mid_max   = max_reg;
        mid_count = count_reg;
        if (join_pt) begin
            mid_open  = 1'b1;
            mid_sum   = sat_sum;
            mid_min   = ($signed(pt_value) < $signed(min_reg)) ? pt_value : min_reg;
            mid_max   = ($signed(max_reg) < $signed(pt_value)) ? pt_value : max_reg;
            mid_count = count_inc;
        end else if (opens) begin
            mid_open  = 1'b1;
            mid_start = pt_time;
            mid_limit = new_limit;
            mid_sum   = v64;
            mid_min   = pt_value;
            mid_max   = pt_value;
            mid_count = COUNT_ONE;
        end
    end

    // which records this point produces
    assign mode_ok = (mode_reg <= MODE_COUNT);
    assign a_emit  = !join_pt && open_reg && mode_ok;
    assign a_final = pt_last && !opens;
    assign b_emit  = pt_last && mid_open && mode_ok;
    assign mk_emit = pt_last && !b_emit && !(a_emit && a_final);

    assign rec_a  = make_rec(mode_reg, start_reg, sum_reg, min_reg, max_reg,
                             count_reg, a_final);
    assign rec_b  = make_rec(mode_reg, mid_start, mid_sum, mid_min, mid_max,
                             mid_count, 1'b1);
    assign rec_mk = {1'b1, {(REC_W-1){1'b0}}};

    // order records: closed bucket, flushed bucket, end marker
    always_comb begin
        priority if (a_emit) begin
            rec_first = rec_a;
        end else if (b_emit) begin
            rec_first = rec_b;
        end else begin
            rec_first = rec_mk;
        end
    end
    assign has_first  = a_emit || b_emit || mk_emit;
    assign rec_second = b_emit ? rec_b : rec_mk;
    assign has_second = a_emit && (b_emit || mk_emit);

    // queue write: pending record first, else the first record of this transaction
    assign rec_push = pend_valid_reg ? !q_full : (acc && has_first);
    assign rec_data = pend_valid_reg ? pend_reg : rec_first;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (pend_valid_reg && !q_full) begin
            pend_valid_next = 1'b0;
        end
        if (acc && has_second) begin
            pend_valid_next = 1'b1;
            pend_next       = rec_second;
        end
    end

    // bucket state update
    always_comb begin
        open_next  = open_reg;
        start_next = start_reg;
        limit_next = limit_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        count_next = count_reg;
        if (acc) begin
            if (pt_last) begin
                open_next  = 1'b0;
                start_next = '0;
                limit_next = '0;
                sum_next   = '0;
                min_next   = '0;
                max_next   = '0;
                count_next = '0;
            end else begin
                open_next  = mid_open;
                start_next = mid_start;
                limit_next = mid_limit;
                sum_next   = mid_sum;
                min_next   = mid_min;
                max_next   = mid_max;
                count_next = mid_count;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= '0;
            range_end_reg   <= {TIME_W{1'b1}};
            blen_reg        <= BLEN_RESET;
            mode_reg        <= MODE_SUM;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RANGE_START:   range_start_reg <= cfg_data[TIME_W-1:0];
                CFG_RANGE_END:     range_end_reg   <= cfg_data[TIME_W-1:0];
                CFG_BUCKET_LENGTH: blen_reg        <= cfg_data[BLEN_W-1:0];
                CFG_REDUCE_MODE:   mode_reg        <= cfg_data[MODE_W-1:0];
                default:           ;
            endcase
        end
    end

    // bucket and pending state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg       <= 1'b0;
            start_reg      <= '0;
            limit_reg      <= '0;
            sum_reg        <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            open_reg       <= open_next;
            start_reg      <= start_next;
            limit_reg      <= limit_next;
            sum_reg        <= sum_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // pending record payload
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

endmodule

### design/tba_queue.sv
// small record queue between front and back ends
module tba_queue import tba_pkg::*; #(
    parameter int WIDTH = 163,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic             do_push, do_pop;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + CNT_W'(1);
            2'b01:   fill_next = fill_reg - CNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/tba_back.sv
// back end: average divider and result output register
`include "time_bucket_aggregator_core_macros.svh"
module tba_back import tba_pkg::*; #(
    parameter int COUNT_WIDTH = 32,
    parameter int REC_W       = 2 * 64 + 32 + 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    // record queue read side
    input  logic [REC_W-1:0]  q_data,
    input  logic              q_empty,
    output logic              q_pop,
    // result stream
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TIME_W-1:0] out_start,
    output logic [RES_W-1:0]  out_result,
    output logic              out_bucket_valid,
    output logic              out_final
);

    localparam int STEP_W = $clog2(RES_W);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(RES_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    // record fields
    logic [TIME_W-1:0]      rec_start;
    logic [RES_W-1:0]       rec_value;
    logic [COUNT_WIDTH-1:0] rec_count;
    logic                   rec_avg;
    logic                   rec_valid;
    logic                   rec_final;

    // divider state
    logic [RES_W-1:0]       quo_reg,   quo_next;
    logic [COUNT_WIDTH-1:0] rem_reg,   rem_next;
    logic [COUNT_WIDTH-1:0] div_reg,   div_next;
    logic [STEP_W-1:0]      step_reg,  step_next;
    logic                   neg_reg,   neg_next;
    logic [TIME_W-1:0]      hstart_reg, hstart_next;
    logic                   hfinal_reg, hfinal_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [TIME_W-1:0] o_start_reg, o_start_next;
    logic [RES_W-1:0]  o_res_reg,   o_res_next;
    logic              o_bval_reg,  o_bval_next;
    logic              o_fin_reg,   o_fin_next;

    logic                 out_free;
    logic                 load_direct;
    logic                 load_div;
    logic [COUNT_WIDTH:0] rem_shift;
    logic [COUNT_WIDTH:0] rem_sub;
    logic                 rem_ge;
    logic [RES_W-1:0]     rec_mag;

    assign {rec_final, rec_valid, rec_avg, rec_count, rec_value, rec_start} = q_data;

    assign out_free    = !m_valid_reg || out_ready;
    assign q_pop       = (state_reg == ST_IDLE) && !q_empty && (rec_avg || out_free);
    assign load_direct = q_pop && !rec_avg;
    assign load_div    = (state_reg == ST_DONE) && out_free;

    // one restoring division step per cycle
    assign rem_shift = {rem_reg, quo_reg[RES_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign rec_mag   = rec_value[RES_W-1] ? (~rec_value + RES_W'(1)) : rec_value;

    // divider sequencer
    always_comb begin
        state_next  = state_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        step_next   = step_reg;
        neg_next    = neg_reg;
        hstart_next = hstart_reg;
        hfinal_next = hfinal_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop && rec_avg) begin
                    quo_next    = rec_mag;
                    rem_next    = '0;
                    div_next    = (rec_count == '0) ? COUNT_WIDTH'(1) : rec_count;
                    step_next   = STEP_FIRST;
                    neg_next    = rec_value[RES_W-1];
                    hstart_next = rec_start;
                    hfinal_next = rec_final;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next  = {quo_reg[RES_W-2:0], rem_ge};
                rem_next  = rem_ge ? rem_sub[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register load and drain
    always_comb begin
        m_valid_next = m_valid_reg;
        o_start_next = o_start_reg;
        o_res_next   = o_res_reg;
        o_bval_next  = o_bval_reg;
        o_fin_next   = o_fin_reg;
        if (m_valid_reg && out_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_direct) begin
            m_valid_next = 1'b1;
            o_start_next = rec_start;
            o_res_next   = rec_value;
            o_bval_next  = rec_valid;
            o_fin_next   = rec_final;
        end else if (load_div) begin
            m_valid_next = 1'b1;
            o_start_next = hstart_reg;
            o_res_next   = neg_reg ? (~quo_reg + RES_W'(1)) : quo_reg;
            o_bval_next  = 1'b1;
            o_fin_next   = hfinal_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        step_reg    <= step_next;
        neg_reg     <= neg_next;
        hstart_reg  <= hstart_next;
        hfinal_reg  <= hfinal_next;
        o_start_reg <= o_start_next;
        o_res_reg   <= o_res_next;
        o_bval_reg  <= o_bval_next;
        o_fin_reg   <= o_fin_next;
    end

    assign out_valid        = m_valid_reg;
    assign out_start        = o_start_reg;
    assign out_result       = o_res_reg;
    assign out_bucket_valid = o_bval_reg;
    assign out_final        = o_fin_reg;

    // checks on the divider and output register
    `TBA_ASSERT_NOW(a_div_nonzero, state_reg == ST_DIV, div_reg != '0, "divide by zero in divider")
    `TBA_ASSERT_NEXT(a_div_ends, (state_reg == ST_DIV) && (step_reg == '0), state_reg == ST_DONE, "divider did not finish after last step")
    `TBA_ASSERT_NOW(a_no_overwrite, load_direct || load_div, !m_valid_reg || out_ready, "result register overwritten before transaction")
    `TBA_ASSERT_NOW(a_pop_idle, q_pop, state_reg == ST_IDLE, "record popped while divider busy")

endmodule

### verif/time_bucket_aggregator_checker.sv
// checker for the time bucket aggregator: mirrors the bucket logic, compares result transactions
`timescale 1ns / 100ps
module time_bucket_aggregator_checker import tba_pkg::*; #(
    parameter int VALUE_WIDTH = 40,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]                    cfg_index,
    input  logic [CFG_W-1:0]                        cfg_data,
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    // s_tdata: point_time, point_value, zero fill
    input  logic [((TIME_W+VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                                    s_tlast,    // end_of_stream
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    // m_tdata: bucket_start, bucket_result
    input  logic [TIME_W+RES_W-1:0]                 m_tdata,
    input  logic                                    m_tuser,    // bucket_valid
    input  logic                                    m_tlast,    // final_result
    output int                                      fail_count,
    output int                                      reports_due
);

    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [RES_W-1:0]  value;
        logic              real_bucket;
        logic              closing;
    } bucket_report_t;

    bucket_report_t due_reports[$];

    // configuration mirror
    logic [TIME_W-1:0] open_lo;
    logic [TIME_W-1:0] open_hi;
    logic [BLEN_W-1:0] span;
    logic [MODE_W-1:0] reduce;

    // open bucket mirror
    logic              in_bucket;
    logic [TIME_W-1:0] first_time;
    logic [TIME_W-1:0] limit_time;
    logic [RES_W-1:0]  sum_acc;
    logic [RES_W-1:0]  min_acc;
    logic [RES_W-1:0]  max_acc;
    logic [63:0]       hits;

    function automatic void clear_bucket();
        in_bucket  = 1'b0;
        first_time = '0;
        limit_time = '0;
        sum_acc    = '0;
        min_acc    = '0;
        max_acc    = '0;
        hits       = '0;
    endfunction

    // closes the open bucket; returns 1 when the mode gives a result
    function automatic bit report_bucket(input bit closing);
        bucket_report_t rep;
        logic [RES_W-1:0] mag;
        logic [RES_W-1:0] quo;
        logic [RES_W-1:0] divisor;
        in_bucket       = 1'b0;
        rep.start       = first_time;
        rep.real_bucket = 1'b1;
        rep.closing     = closing;
        case (reduce)
            MODE_SUM: rep.value = sum_acc;
            MODE_AVG: begin
                // truncate toward zero: divide the magnitude, then restore the sign
                mag       = sum_acc[RES_W-1] ? -sum_acc : sum_acc;
                divisor   = (hits == 0) ? 64'd1 : hits;
                quo       = mag / divisor;
                rep.value = sum_acc[RES_W-1] ? -quo : quo;
            end
            MODE_MIN:   rep.value = min_acc;
            MODE_MAX:   rep.value = max_acc;
            MODE_COUNT: rep.value = hits;
            default:    return 1'b0;
        endcase
        due_reports = {due_reports, rep};
        return 1'b1;
    endfunction

    // one accepted point: update the bucket mirror and queue the results it causes
    function automatic void fold_point(input logic [TIME_W-1:0] t,
                                       input logic [VALUE_WIDTH-1:0] raw, input logic last);
        logic [RES_W-1:0] v;
        logic [RES_W-1:0] r;
        logic [TIME_W-1:0] len;
        bit in_range;
        bit final_given;
        bucket_report_t marker;
        v = {{(RES_W-VALUE_WIDTH){raw[VALUE_WIDTH-1]}}, raw};
        final_given = 1'b0;
        if (in_bucket && t < limit_time) begin
            // joins the open bucket, sum saturates at the signed bounds
            r = sum_acc + v;
            if (sum_acc[RES_W-1] == v[RES_W-1] && r[RES_W-1] != sum_acc[RES_W-1])
                r = sum_acc[RES_W-1] ? RES_MIN : RES_MAX;
            sum_acc = r;
            if ($signed(v) < $signed(min_acc))
                min_acc = v;
            if ($signed(v) > $signed(max_acc))
                max_acc = v;
            if (hits < COUNT_MAX)
                hits = hits + 64'd1;
        end else begin
            in_range = (t >= open_lo) && (t <= open_hi);
            if (in_bucket) begin
                if (report_bucket(last && !in_range))
                    final_given = last && !in_range;
            end
            if (in_range) begin
                // open a new bucket, zero length counts as one, limit saturates
                len        = (span == 0) ? 64'd1 : TIME_W'(span);
                in_bucket  = 1'b1;
                first_time = t;
                limit_time = (t > ~len) ? '1 : t + len;
                sum_acc    = v;
                min_acc    = v;
                max_acc    = v;
                hits       = 64'd1;
            end
        end
        if (last) begin
            if (in_bucket) begin
                if (report_bucket(1'b1))
                    final_given = 1'b1;
            end
            // bare end marker when nothing carried the final flag
            if (!final_given) begin
                marker.start       = '0;
                marker.value       = '0;
                marker.real_bucket = 1'b0;
                marker.closing     = 1'b1;
                due_reports = {due_reports, marker};
            end
            clear_bucket();
        end
    endfunction

    function automatic void compare_field(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endfunction

    // watch all three channels at the rising edge
    always @(posedge aclk) begin
        bucket_report_t want;
        if (!aresetn) begin
            open_lo = '0;
            open_hi = '1;
            span    = BLEN_RESET;
            reduce  = MODE_SUM;
            clear_bucket();
            due_reports.delete();
        end else begin
            // register write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RANGE_START:   open_lo = cfg_data;
                    CFG_RANGE_END:     open_hi = cfg_data;
                    CFG_BUCKET_LENGTH: span    = cfg_data[BLEN_W-1:0];
                    CFG_REDUCE_MODE:   reduce  = cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            // point transaction
            if (s_tvalid && s_tready)
                fold_point(s_tdata[TIME_W-1:0], s_tdata[TIME_W +: VALUE_WIDTH], s_tlast);
            // result transaction
            if (m_tvalid && m_tready) begin
                if (due_reports.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got %h %h %b %b",
                             $time, m_tdata[TIME_W-1:0], m_tdata[TIME_W +: RES_W],
                             m_tuser, m_tlast);
                end else begin
                    want = due_reports.pop_front();
                    compare_field("bucket_start", want.start, m_tdata[TIME_W-1:0]);
                    compare_field("bucket_result", want.value, m_tdata[TIME_W +: RES_W]);
                    compare_field("bucket_valid", 64'(want.real_bucket), 64'(m_tuser));
                    compare_field("final_result", 64'(want.closing), 64'(m_tlast));
                end
            end
        end
        reports_due = due_reports.size();
    end

endmodule

### verif/time_bucket_aggregator_core_tb.sv
// testbench top for the time bucket aggregator core: drives points and registers, gives the verdict
`timescale 1ns / 100ps
module time_bucket_aggregator_core_tb;
    import tba_pkg::*;

    localparam int VALUE_WIDTH   = 40;
    localparam int COUNT_WIDTH   = 32;
    localparam int S_DATA_W      = ((TIME_W + VALUE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_POINTS = 400;
    localparam int QUIET_AFTER   = 320;
    localparam int PRESSURE_RUN  = 60;
    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [TIME_W-1:0]      T_MAX = '1;
    localparam logic [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;     // point_time, point_value
    logic                 s_tlast;     // end_of_stream
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TIME_W+RES_W-1:0] m_tdata;  // bucket_start, bucket_result
    logic                 m_tuser;     // bucket_valid
    logic                 m_tlast;     // final_result

    int fail_count;
    int reports_due;
    int points_sent = 0;
    int cycles      = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;

    time_bucket_aggregator_core #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    time_bucket_aggregator_checker #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .reports_due(reports_due)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one register write transaction, valid stays up for the next write
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic configure(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi,
                             input logic [BLEN_W-1:0] len, input logic [MODE_W-1:0] mode);
        put_reg(CFG_RANGE_START, lo);
        put_reg(CFG_RANGE_END, hi);
        put_reg(CFG_BUCKET_LENGTH, CFG_W'(len));
        put_reg(CFG_REDUCE_MODE, CFG_W'(mode));
        cfg_valid = 1'b0;
    endtask

    // one point transaction, with an optional idle burst in front
    task automatic send_point(input logic [TIME_W-1:0] t, input logic [VALUE_WIDTH-1:0] v,
                              input logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tdata  = S_DATA_W'({v, t});
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        points_sent++;
    endtask

    // wait until every predicted result is out, then let the divider drain
    task automatic settle();
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (reports_due != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // one series with random settings, ended by an end-of-stream point
    task automatic random_stream();
        logic [TIME_W-1:0]      t;
        logic [TIME_W-1:0]      lo;
        logic [TIME_W-1:0]      hi;
        logic [TIME_W-1:0]      step;
        logic [BLEN_W-1:0]      len;
        logic [MODE_W-1:0]      mode;
        logic [VALUE_WIDTH-1:0] v;
        int n;
        int pace;
        int i;
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = '1;
            default: len = BLEN_W'($urandom_range(1, 40));
        endcase
        if ($urandom_range(0, 15) == 0)
            mode = MODE_COUNT + MODE_W'($urandom_range(1, 3));
        else
            mode = MODE_W'($urandom_range(MODE_SUM, MODE_COUNT));
        case ($urandom_range(0, 7))
            0:       t = '0;
            1:       t = T_MAX - TIME_W'($urandom_range(0, 300));
            default: t = {$urandom, $urandom};
        endcase
        // mostly an open range, sometimes a window, a random pair or an inverted one
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                lo = '0;
                hi = T_MAX;
            end
            3: begin
                lo = t + TIME_W'($urandom_range(0, 100));
                hi = lo + TIME_W'($urandom_range(0, 200));
            end
            4: begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            default: begin
                lo = t + TIME_W'($urandom_range(50, 100));
                hi = lo - TIME_W'($urandom_range(1, 40));
            end
        endcase
        pace = (len == 0 || len > 40) ? 20 : int'(len);
        n    = $urandom_range(4, 20);
        configure(lo, hi, len, mode);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
                0:       v = V_MAX;
                1:       v = V_MIN;
                default: v = VALUE_WIDTH'({$urandom, $urandom});
            endcase
            send_point(t, v, i == n - 1);
            case ($urandom_range(0, 19))
                0:       step = TIME_W'($urandom_range(500, 5000));
                1, 2, 3: step = '0;
                default: step = TIME_W'($urandom_range(0, 2 * pace));
            endcase
            t = (t > T_MAX - step) ? T_MAX : t + step;
        end
        settle();
    endtask

    // result side: random stall bursts, plus one long hold on request
    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_tready = 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready = 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // run limit
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int i;
        int random_base;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RANGE_START;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset defaults: sum over 60 units, value extremes, close then flush
        send_point(64'd0, V_MAX, 1'b0);
        send_point(64'd30, V_MAX, 1'b0);
        send_point(64'd59, V_MIN, 1'b0);
        send_point(64'd60, '1, 1'b0);
        send_point(64'd200, VALUE_WIDTH'(5), 1'b1);
        settle();

        // minimum
        configure('0, T_MAX, 32'd10, MODE_MIN);
        send_point(64'd5, VALUE_WIDTH'(3), 1'b0);
        send_point(64'd6, VALUE_WIDTH'(-7), 1'b0);
        send_point(64'd15, VALUE_WIDTH'(2), 1'b1);
        settle();

        // maximum with zero bucket length
        configure('0, T_MAX, '0, MODE_MAX);
        send_point(64'd7, VALUE_WIDTH'(-9), 1'b0);
        send_point(64'd7, VALUE_WIDTH'(-3), 1'b0);
        send_point(64'd8, VALUE_WIDTH'(4), 1'b1);
        settle();

        // count with the bucket limit saturated at the top timestamp
        configure('0, T_MAX, '1, MODE_COUNT);
        send_point(T_MAX - 64'd1, VALUE_WIDTH'(1), 1'b0);
        send_point(T_MAX, VALUE_WIDTH'(2), 1'b1);
        settle();

        // average over a window, with points outside it skipped
        configure(64'd100, 64'd200, 32'd60, MODE_AVG);
        send_point(64'd50, VALUE_WIDTH'(1), 1'b0);
        send_point(64'd150, VALUE_WIDTH'(-7), 1'b0);
        send_point(64'd180, VALUE_WIDTH'(2), 1'b0);
        send_point(64'd300, VALUE_WIDTH'(9), 1'b0);
        send_point(64'd400, VALUE_WIDTH'(1), 1'b1);
        settle();

        // inverted range: only the end marker comes out
        configure(64'd300, 64'd100, 32'd60, MODE_SUM);
        send_point(64'd150, VALUE_WIDTH'(1), 1'b0);
        send_point(64'd250, VALUE_WIDTH'(1), 1'b1);
        settle();

        // unknown reduce mode: buckets close silently
        configure('0, T_MAX, 32'd5, MODE_COUNT + 1'b1);
        send_point(64'd1, VALUE_WIDTH'(1), 1'b0);
        send_point(64'd10, VALUE_WIDTH'(2), 1'b0);
        send_point(64'd11, VALUE_WIDTH'(3), 1'b1);
        settle();

        // final point closes a bucket without opening one
        configure('0, 64'd100, 32'd60, MODE_SUM);
        send_point(64'd10, VALUE_WIDTH'(1), 1'b0);
        send_point(64'd200, VALUE_WIDTH'(1), 1'b1);
        settle();

        // pressure: result side holds off while one-unit buckets keep closing
        random_base = points_sent;
        configure('0, T_MAX, 32'd1, MODE_SUM);
        hold_req = 1'b1;
        for (i = 0; i < PRESSURE_RUN; i++)
            send_point(TIME_W'(1000 + i), VALUE_WIDTH'({$urandom, $urandom}),
                       i == PRESSURE_RUN - 1);
        settle();

        // random series, the last stretch without idling
        while (points_sent - random_base < RANDOM_POINTS) begin
            if (points_sent - random_base >= QUIET_AFTER)
                quiet = 1'b1;
            random_stream();
        end

        settle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
